// File: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; included where concurrent checks are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk_s, rst_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) \
    else $error("forbidden condition seen");

`endif

// File: hw/rtl/tmg_pkg.sv
// shared types and constants of the trackpad mouse gesture core
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tmg_pkg;

  // result slots in emission order; each queued command enables a subset
  localparam int NUM_SLOTS     = 7;
  localparam int SLOT_MOVE     = 0;  // pad motion report
  localparam int SLOT_RIGHT_ON = 1;  // right press after long hold
  localparam int SLOT_HAPTIC   = 2;  // haptic pulse
  localparam int SLOT_BTN_B    = 3;  // right release or left press of a click
  localparam int SLOT_LEFT_OFF = 4;  // left release of a click
  localparam int SLOT_PADDLE1  = 5;
  localparam int SLOT_PADDLE2  = 6;

  localparam int SLOT_W = $clog2(NUM_SLOTS);

  localparam logic [1:0] BTN_LEFT  = 2'b01;
  localparam logic [1:0] BTN_RIGHT = 2'b10;

  localparam logic       KIND_MOUSE  = 1'b0;
  localparam logic       KIND_HAPTIC = 1'b1;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic        TRACKING_ENABLED_RST = 1'b1;
  localparam logic        FIRMWARE_MOUSE_RST   = 1'b0;
  localparam logic        PADDLES_ENABLED_RST  = 1'b1;
  localparam logic [4:0]  MOVE_GAIN_RST        = 5'd1;
  localparam logic [15:0] HOLD_MS_RST          = 16'd500;
  localparam logic [15:0] AREA_MIN_RST         = 16'd16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TRACKING_ENABLED = 3'd0,
    CFG_FIRMWARE_MOUSE   = 3'd1,
    CFG_PADDLES_ENABLED  = 3'd2,
    CFG_MOVE_GAIN        = 3'd3,
    CFG_HOLD_MS          = 3'd4,
    CFG_AREA_MIN         = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic               track_valid;
    logic               pad_touch;
    logic signed [15:0] pad_x;
    logic signed [15:0] pad_y;
    logic               click_valid;
    logic               other_touch;
    logic               other_hard_click;
    logic        [15:0] other_area;
    logic               paddle_one;
    logic               paddle_two;
    logic        [31:0] now_ms;
  } rpt_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic               left_down;
    logic               right_down;
    logic               last;
  } evt_t;

  // one classified report: enabled slots, motion, button state per slot
  typedef struct packed {
    logic [NUM_SLOTS-1:0]      mask;
    logic [15:0]               move_x;
    logic [15:0]               move_y;
    logic [NUM_SLOTS-1:0][1:0] btn;
  } cmd_t;

endpackage

// File: hw/rtl/tmg_front.sv
// front end: config registers, gesture state, report classification
// depends on tmg_pkg; feeds tmg_queue with at most one command per report
`timescale 1ns / 1ps

module tmg_front import tmg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   rpt_valid,
  output logic                   rpt_ready,
  input  rpt_t                   rpt,
  input  logic                   q_full,
  output logic                   q_push,
  output cmd_t                   q_cmd
);

  logic        tracking_enabled;
  logic        firmware_mouse;
  logic        paddles_enabled;
  logic [4:0]  move_gain;
  logic [15:0] hold_ms;
  logic [15:0] area_min;

  logic               was_touching;
  logic signed [15:0] last_x;
  logic signed [15:0] last_y;
  logic               press_active;
  logic               right_held;
  logic [31:0]        press_start;
  logic               prev_paddle_one;
  logic               prev_paddle_two;
  logic [1:0]         buttons;

  logic        accept;
  logic        trk_active;
  logic        pos_moved;
  logic [15:0] dx;
  logic [15:0] dy;
  logic [20:0] prod_x;
  logic [20:0] prod_y;
  logic        pressed;
  logic [31:0] elapsed;
  logic        hold_evt;
  logic        rel_evt;
  logic        click_evt;
  logic        p1_evt;
  logic        p2_evt;
  logic [1:0]  b_a, b_b, b_c, b_d, b_e;

  assign cfg_ready = 1'b1;
  assign rpt_ready = !q_full;
  assign accept    = rpt_valid && rpt_ready;

  always_comb begin
    trk_active = !firmware_mouse && rpt.track_valid && tracking_enabled;
    pos_moved  = (rpt.pad_x != last_x) || (rpt.pad_y != last_y);
    dx         = rpt.pad_x - last_x;
    dy         = last_y - rpt.pad_y;
    prod_x     = {5'b0, dx} * {16'b0, move_gain};
    prod_y     = {5'b0, dy} * {16'b0, move_gain};

    pressed   = rpt.click_valid && rpt.other_touch && rpt.other_hard_click &&
                (rpt.other_area >= area_min);
    elapsed   = rpt.now_ms - press_start;
    hold_evt  = pressed && press_active && !right_held && (elapsed >= {16'b0, hold_ms});
    rel_evt   = !pressed && press_active;
    click_evt = rel_evt && !right_held;

    // button state walks through the slots in emission order
    b_a = hold_evt ? (buttons | BTN_RIGHT) : buttons;
    if (rel_evt) begin
      b_b = right_held ? (b_a & ~BTN_RIGHT) : (b_a | BTN_LEFT);
    end else begin
      b_b = b_a;
    end
    b_c = click_evt ? (b_b & ~BTN_LEFT) : b_b;
    p1_evt = paddles_enabled && (rpt.paddle_one != prev_paddle_one);
    b_d = p1_evt ? {b_c[1], rpt.paddle_one} : b_c;
    p2_evt = paddles_enabled && (rpt.paddle_two != prev_paddle_two);
    b_e = p2_evt ? {rpt.paddle_two, b_d[0]} : b_d;

    q_cmd = '0;
    q_cmd.mask[SLOT_MOVE]     = trk_active && rpt.pad_touch && was_touching && pos_moved;
    q_cmd.mask[SLOT_RIGHT_ON] = b_a != buttons;
    q_cmd.mask[SLOT_HAPTIC]   = hold_evt || click_evt;
    q_cmd.mask[SLOT_BTN_B]    = b_b != b_a;
    q_cmd.mask[SLOT_LEFT_OFF] = b_c != b_b;
    q_cmd.mask[SLOT_PADDLE1]  = b_d != b_c;
    q_cmd.mask[SLOT_PADDLE2]  = b_e != b_d;
    q_cmd.move_x              = prod_x[15:0];
    q_cmd.move_y              = prod_y[15:0];
    q_cmd.btn[SLOT_MOVE]      = buttons;
    q_cmd.btn[SLOT_RIGHT_ON]  = b_a;
    q_cmd.btn[SLOT_BTN_B]     = b_b;
    q_cmd.btn[SLOT_LEFT_OFF]  = b_c;
    q_cmd.btn[SLOT_PADDLE1]   = b_d;
    q_cmd.btn[SLOT_PADDLE2]   = b_e;

    q_push = accept && (|q_cmd.mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking_enabled <= TRACKING_ENABLED_RST;
      firmware_mouse   <= FIRMWARE_MOUSE_RST;
      paddles_enabled  <= PADDLES_ENABLED_RST;
      move_gain        <= MOVE_GAIN_RST;
      hold_ms          <= HOLD_MS_RST;
      area_min         <= AREA_MIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TRACKING_ENABLED: tracking_enabled <= cfg_data[0];
        CFG_FIRMWARE_MOUSE:   firmware_mouse   <= cfg_data[0];
        CFG_PADDLES_ENABLED:  paddles_enabled  <= cfg_data[0];
        CFG_MOVE_GAIN:        move_gain        <= cfg_data[4:0];
        CFG_HOLD_MS:          hold_ms          <= cfg_data;
        CFG_AREA_MIN:         area_min         <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_touching    <= 1'b0;
      last_x          <= '0;
      last_y          <= '0;
      press_active    <= 1'b0;
      right_held      <= 1'b0;
      press_start     <= '0;
      prev_paddle_one <= 1'b0;
      prev_paddle_two <= 1'b0;
      buttons         <= '0;
    end else if (accept) begin
      if (trk_active) begin
        was_touching <= rpt.pad_touch;
        if (rpt.pad_touch) begin
          last_x <= rpt.pad_x;
          last_y <= rpt.pad_y;
        end
      end
      if (pressed && !press_active) begin
        press_active <= 1'b1;
        press_start  <= rpt.now_ms;
        right_held   <= 1'b0;
      end else if (hold_evt) begin
        right_held <= 1'b1;
      end else if (rel_evt) begin
        press_active <= 1'b0;
        right_held   <= 1'b0;
        press_start  <= '0;
      end
      if (p1_evt) prev_paddle_one <= rpt.paddle_one;
      if (p2_evt) prev_paddle_two <= rpt.paddle_two;
      buttons <= b_e;
    end
  end

endmodule

// File: hw/rtl/tmg_queue.sv
// short command queue between front and back ends
// depends on tmg_pkg for cmd_t and assert_macros.svh for checks
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tmg_queue import tmg_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_NEVER(a_no_push_full, clk, rst, push && full)
  `ASSERT_NEVER(a_no_pop_empty, clk, rst, pop && !head_valid)

endmodule

// File: hw/rtl/tmg_back.sv
// back end: walks the enabled slots of the head command, one result a beat
// depends on tmg_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tmg_back import tmg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic head_valid,
  input  cmd_t head,
  output logic pop,
  output logic evt_valid,
  input  logic evt_ready,
  output evt_t evt
);

  logic [NUM_SLOTS-1:0] done;
  logic [NUM_SLOTS-1:0] rem;
  logic [NUM_SLOTS-1:0] pick;
  logic [SLOT_W-1:0]    pick_idx;
  logic                 pick_last;
  logic                 load;
  evt_t                 evt_next;

  always_comb begin
    rem       = head.mask & ~done;
    pick      = rem & (~rem + 1'b1);
    pick_last = (rem & ~pick) == '0;
    pick_idx  = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (pick[i]) pick_idx = SLOT_W'(i);
    end

    evt_next            = '0;
    evt_next.kind       = (int'(pick_idx) == SLOT_HAPTIC) ? KIND_HAPTIC : KIND_MOUSE;
    if (int'(pick_idx) == SLOT_MOVE) begin
      evt_next.move_x = head.move_x;
      evt_next.move_y = head.move_y;
    end
    if (int'(pick_idx) != SLOT_HAPTIC) begin
      evt_next.left_down  = head.btn[pick_idx][0];
      evt_next.right_down = head.btn[pick_idx][1];
    end
    evt_next.last       = pick_last;
  end

  assign load = head_valid && (!evt_valid || evt_ready);
  assign pop  = load && pick_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= '0;
      evt_valid <= 1'b0;
    end else begin
      if (load) begin
        evt_valid <= 1'b1;
        done      <= pick_last ? '0 : (done | pick);
      end else if (evt_ready) begin
        evt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) evt <= evt_next;
  end

  `ASSERT_PROP(a_head_has_work, clk, rst, head_valid |-> (rem != '0))
  `ASSERT_PROP(a_pop_clears_done, clk, rst, pop |=> (done == '0))
  `ASSERT_PROP(a_done_within_mask, clk, rst, head_valid |-> ((done & ~head.mask) == '0))

endmodule

// File: hw/rtl/trackpad_mouse_gesture_core.sv
// top level of the trackpad mouse gesture core
// depends on tmg_pkg, tmg_front, tmg_queue and tmg_back
`timescale 1ns / 1ps

// channel | signals                                   | beat moves
// --------+-------------------------------------------+---------------------------
// cfg     | cfg_valid cfg_ready cfg_index cfg_data    | one register write
// rpt     | rpt_valid rpt_ready rpt                   | one decoded controller report
// evt     | evt_valid evt_ready evt                   | one mouse report or haptic pulse
//
// a report is taken whenever the command queue has room; the front end
// updates all gesture state in the cycle that it takes the report and
// queues the results it causes. the back end sends one result per cycle
// while the output is ready, so a report with n results (at most six) holds
// the output until all n are sent; the output register is the pacing point.
// the first result is held in a queue slot, then in the output register.
// synchronous reset clears queue, state and config to defaults.
// a stalled output only blocks reports once the queue has filled.

module trackpad_mouse_gesture_core import tmg_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   rpt_valid,
  output logic                   rpt_ready,
  input  rpt_t                   rpt,
  output logic                   evt_valid,
  input  logic                   evt_ready,
  output evt_t                   evt
);

  // front to queue
  logic q_push;
  cmd_t q_cmd;
  logic q_full;
  // queue to back
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  // classification and gesture state
  tmg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rpt_valid (rpt_valid),
    .rpt_ready (rpt_ready),
    .rpt       (rpt),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  // decouples report intake from result delivery
  tmg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // serializes enabled result slots onto the output
  tmg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .evt_valid  (evt_valid),
    .evt_ready  (evt_ready),
    .evt        (evt)
  );

endmodule
